/* design/contiguous_fit_allocator_unit_assert.svh */
// Assertion macros shared by the checker of the contiguous fit allocator.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CFA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cfa_pkg.sv */
package cfa_pkg;

   typedef logic [2:0] opcode_type;
   typedef logic [7:0] owner_type;
   typedef logic [6:0] size_type;
   typedef logic [5:0] index_type;
   typedef logic [5:0] start_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] rule_type;

   localparam owner_type FREE_MARK = 8'h2E;

   localparam opcode_type OP_FIRST_FIT = 3'd0;
   localparam opcode_type OP_BEST_FIT  = 3'd1;
   localparam opcode_type OP_WORST_FIT = 3'd2;
   localparam opcode_type OP_FREE      = 3'd3;
   localparam opcode_type OP_COMPACT   = 3'd4;
   localparam opcode_type OP_READ      = 3'd5;

   localparam status_type STATUS_DONE    = 2'd0;
   localparam status_type STATUS_NOSPACE = 2'd1;
   localparam status_type STATUS_INVALID = 2'd2;

   localparam rule_type RULE_FIRST = 2'd0;
   localparam rule_type RULE_BEST  = 2'd1;
   localparam rule_type RULE_WORST = 2'd2;

   // Control from the sequencer to the run finder.
   typedef struct packed {
      logic     clear;
      logic     step;
      logic     is_free;
      rule_type rule;
   } run_ctl_type;

   function automatic rule_type rule_of(input opcode_type op);
      rule_type r;
      r = RULE_FIRST;
      unique case (op)
         OP_BEST_FIT:  r = RULE_BEST;
         OP_WORST_FIT: r = RULE_WORST;
         default:      r = RULE_FIRST;
      endcase
      return r;
   endfunction

endpackage

/* design/cfa_chan_if.sv */
interface cfa_req_if;
   logic                   valid;
   logic                   ready;
   cfa_pkg::opcode_type    opcode;
   cfa_pkg::owner_type     owner;
   cfa_pkg::size_type      alloc_size;
   cfa_pkg::index_type     cell_index;

   modport source (output valid, opcode, owner, alloc_size, cell_index, input ready);
   modport sink   (input valid, opcode, owner, alloc_size, cell_index, output ready);
endinterface

interface cfa_rsp_if;
   logic                   valid;
   logic                   ready;
   cfa_pkg::status_type    status;
   cfa_pkg::start_type     alloc_start;
   cfa_pkg::owner_type     cell_owner;

   modport source (output valid, status, alloc_start, cell_owner, input ready);
   modport sink   (input valid, status, alloc_start, cell_owner, output ready);
endinterface

/* design/cfa_pool_mem.sv */
module cfa_pool_mem #(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  cfa_pkg::owner_type       wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output cfa_pkg::owner_type       rd_data
);
   cfa_pkg::owner_type pool_ff [DEPTH];
   cfa_pkg::owner_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pool_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= pool_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/cfa_run_finder.sv */
module cfa_run_finder #(
   parameter int POOL_CELLS = 64,
   localparam int AW = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1,
   localparam int CW = $clog2(POOL_CELLS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfa_pkg::run_ctl_type  ctl,
   input  logic [CW-1:0]         addr,
   input  cfa_pkg::size_type     need,
   output logic                  found,
   output logic [AW-1:0]         best_start
);
   localparam int MW = (CW > 7) ? CW : 7;

   logic [AW-1:0] run_start_ff, run_start_in;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic          found_ff, found_in;
   logic [AW-1:0] best_start_ff, best_start_in;
   logic [CW-1:0] best_len_ff, best_len_in;
   logic          fits;
   logic          better;

   assign fits   = (MW'(run_len_ff) >= MW'(need)) && (run_len_ff != '0);
   assign better = ((ctl.rule == cfa_pkg::RULE_BEST)  && (run_len_ff < best_len_ff)) ||
                   ((ctl.rule == cfa_pkg::RULE_WORST) && (run_len_ff > best_len_ff));

   always_comb begin
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      found_in      = found_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      if (ctl.clear) begin
         run_len_in = '0;
         found_in   = 1'b0;
      end else if (ctl.step) begin
         if (ctl.is_free) begin
            if (run_len_ff == '0) begin
               run_start_in = AW'(addr);
            end
            run_len_in = run_len_ff + 1'b1;
         end else begin
            if (fits && (!found_ff || better)) begin
               found_in      = 1'b1;
               best_start_in = run_start_ff;
               best_len_in   = run_len_ff;
            end
            run_len_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         run_len_ff <= '0;
      end else begin
         found_ff   <= found_in;
         run_len_ff <= run_len_in;
      end
   end

   always_ff @(posedge clock) begin
      run_start_ff  <= run_start_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
   end

   assign found      = found_ff;
   assign best_start = best_start_ff;
endmodule

/* design/contiguous_fit_allocator_unit.sv */
// Contiguous fit allocator: a pool of POOL_CELLS owner cells in one synchronous RAM.
// Requests arrive on req_chan (opcode, owner, alloc_size, cell_index) and each gives
// exactly one response on rsp_chan (status, alloc_start, cell_owner); both channels
// use a valid/ready handshake and a request moves on the edge where both are high.
// One request is worked on at a time; req_chan.ready is high only while the sequencer
// is idle, from the cycle after a response is loaded.
// Work per request, N = POOL_CELLS:
//   first/best/worst fit : scan pass, then one write per cell; no-space status
//                          when no run fits or for a size of zero or above N
//   free owner           : read-modify-write pass
//   compact              : move pass, then free fill of the top
//   read cell            : one read of the cell;  invalid opcode : invalid status
// The pool RAM has a single read port and a single write port, so each pass
// handles one cell per cycle.
// Reset starts a clearing sweep that writes the free marker to every cell; no
// request is taken until it ends.
// The response sits in an output register; while the receiver stalls it holds,
// and the next request is still accepted and worked on. A finished response then
// waits in the sequencer until the output register drains.
module contiguous_fit_allocator_unit #(
   parameter int POOL_CELLS = 64
) (
   input  logic       clock,
   input  logic       reset,
   cfa_req_if.sink    req_chan,
   cfa_rsp_if.source  rsp_chan
);
   localparam int AW = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
   localparam int CW = $clog2(POOL_CELLS + 1);
   localparam int MW = (CW > 7) ? CW : 7;

   // Sequencer states.
   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_PASS      = 4'd2;
   localparam logic [3:0] S_DECIDE    = 4'd3;
   localparam logic [3:0] S_WRITE     = 4'd4;
   localparam logic [3:0] S_FILL      = 4'd5;
   localparam logic [3:0] S_READ      = 4'd6;
   localparam logic [3:0] S_READ_WAIT = 4'd7;
   localparam logic [3:0] S_RESP      = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         ptr_ff, ptr_in;          // sweep, issue, write and fill pointer
   logic                  issue_done_ff, issue_done_in;
   logic                  proc_vld_ff, proc_vld_in;
   logic [CW-1:0]         proc_addr_ff, proc_addr_in;
   logic [CW-1:0]         dst_ff, dst_in;          // compact destination
   cfa_pkg::size_type     rem_ff, rem_in;
   cfa_pkg::opcode_type   op_ff, op_in;
   cfa_pkg::owner_type    owner_ff, owner_in;
   cfa_pkg::size_type     size_ff, size_in;
   cfa_pkg::index_type    idx_ff, idx_in;
   cfa_pkg::status_type   res_status_ff, res_status_in;
   cfa_pkg::start_type    res_start_ff, res_start_in;
   cfa_pkg::owner_type    res_cell_ff, res_cell_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfa_pkg::status_type   rsp_status_ff, rsp_status_in;
   cfa_pkg::start_type    rsp_start_ff, rsp_start_in;
   cfa_pkg::owner_type    rsp_cell_ff, rsp_cell_in;

   logic                  req_accept;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   cfa_pkg::owner_type    mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   cfa_pkg::owner_type    mem_rd_data;
   cfa_pkg::run_ctl_type  run_ctl;
   logic                  run_found;
   logic [AW-1:0]         run_best_start;
   logic                  proc_in_pool;
   logic                  idx_in_pool;
   logic                  op_is_alloc;

   cfa_pool_mem #(
      .DEPTH (POOL_CELLS)
   ) u_pool_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cfa_run_finder #(
      .POOL_CELLS (POOL_CELLS)
   ) u_run_finder (
      .clock      (clock),
      .reset      (reset),
      .ctl        (run_ctl),
      .addr       (proc_addr_ff),
      .need       (size_ff),
      .found      (run_found),
      .best_start (run_best_start)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The pass runs one step beyond the top: that step sees a used cell and closes any
   // run that ends at the top of the pool.
   assign proc_in_pool = (proc_addr_ff < CW'(POOL_CELLS));
   assign idx_in_pool  = (MW'(idx_ff) < MW'(POOL_CELLS));
   assign op_is_alloc  = (op_ff == cfa_pkg::OP_FIRST_FIT) ||
                         (op_ff == cfa_pkg::OP_BEST_FIT)  ||
                         (op_ff == cfa_pkg::OP_WORST_FIT);

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      issue_done_in = issue_done_ff;
      proc_vld_in   = 1'b0;
      proc_addr_in  = proc_addr_ff;
      dst_in        = dst_ff;
      rem_in        = rem_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_cell_in   = res_cell_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_cell_in   = rsp_cell_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = AW'(ptr_ff);
      mem_wr_data   = cfa_pkg::FREE_MARK;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = AW'(ptr_ff);
      run_ctl.clear   = 1'b0;
      run_ctl.step    = 1'b0;
      run_ctl.is_free = 1'b0;
      run_ctl.rule    = cfa_pkg::rule_of(op_ff);

      // Drop the response once the receiver takes it.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en = 1'b1;
            if (ptr_ff == CW'(POOL_CELLS - 1)) begin
               ptr_in   = '0;
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_chan.opcode;
               owner_in      = req_chan.owner;
               size_in       = req_chan.alloc_size;
               idx_in        = req_chan.cell_index;
               res_status_in = cfa_pkg::STATUS_DONE;
               res_start_in  = '0;
               res_cell_in   = '0;
               ptr_in        = '0;
               dst_in        = '0;
               issue_done_in = 1'b0;
               unique case (req_chan.opcode)
                  cfa_pkg::OP_FIRST_FIT, cfa_pkg::OP_BEST_FIT, cfa_pkg::OP_WORST_FIT: begin
                     if ((req_chan.alloc_size == '0) ||
                         (MW'(req_chan.alloc_size) > MW'(POOL_CELLS))) begin
                        res_status_in = cfa_pkg::STATUS_NOSPACE;
                        state_in      = S_RESP;
                     end else begin
                        run_ctl.clear = 1'b1;
                        state_in      = S_PASS;
                     end
                  end
                  cfa_pkg::OP_FREE, cfa_pkg::OP_COMPACT: begin
                     state_in = S_PASS;
                  end
                  cfa_pkg::OP_READ: begin
                     state_in = S_READ;
                  end
                  default: begin
                     res_status_in = cfa_pkg::STATUS_INVALID;
                     state_in      = S_RESP;
                  end
               endcase
            end
         end

         S_PASS: begin
            // Issue side: one read a cycle, then the closing step past the top.
            if (!issue_done_ff) begin
               mem_rd_en    = (ptr_ff < CW'(POOL_CELLS));
               mem_rd_addr  = AW'(ptr_ff);
               proc_vld_in  = 1'b1;
               proc_addr_in = ptr_ff;
               if (ptr_ff == CW'(POOL_CELLS)) begin
                  issue_done_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            // Process side: data of the cell read in the previous cycle.
            if (proc_vld_ff) begin
               if (op_is_alloc) begin
                  run_ctl.step    = 1'b1;
                  run_ctl.is_free = proc_in_pool && (mem_rd_data == cfa_pkg::FREE_MARK);
               end else if (op_ff == cfa_pkg::OP_FREE) begin
                  mem_wr_addr = AW'(proc_addr_ff);
                  mem_wr_en   = proc_in_pool && (owner_ff != cfa_pkg::FREE_MARK) &&
                                (mem_rd_data == owner_ff);
               end else begin
                  // Compact: move each used cell to the next destination slot.
                  if (proc_in_pool && (mem_rd_data != cfa_pkg::FREE_MARK)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(dst_ff);
                     mem_wr_data = mem_rd_data;
                     dst_in      = dst_ff + 1'b1;
                  end
               end
               if (!proc_in_pool) begin
                  priority if (op_is_alloc) begin
                     state_in = S_DECIDE;
                  end else if (op_ff == cfa_pkg::OP_FREE) begin
                     state_in = S_RESP;
                  end else begin
                     ptr_in   = dst_ff;
                     state_in = S_FILL;
                  end
               end
            end
         end

         S_DECIDE: begin
            if (run_found) begin
               ptr_in       = CW'(run_best_start);
               rem_in       = size_ff;
               res_start_in = 6'(run_best_start);
               state_in     = S_WRITE;
            end else begin
               res_status_in = cfa_pkg::STATUS_NOSPACE;
               state_in      = S_RESP;
            end
         end

         S_WRITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = owner_ff;
            ptr_in      = ptr_ff + 1'b1;
            rem_in      = rem_ff - 1'b1;
            if (rem_ff == 7'd1) begin
               state_in = S_RESP;
            end
         end

         S_FILL: begin
            if (ptr_ff == CW'(POOL_CELLS)) begin
               state_in = S_RESP;
            end else begin
               mem_wr_en = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end
         end

         S_READ: begin
            mem_rd_en   = idx_in_pool;
            mem_rd_addr = AW'(idx_ff);
            state_in    = S_READ_WAIT;
         end

         S_READ_WAIT: begin
            res_cell_in = idx_in_pool ? mem_rd_data : cfa_pkg::FREE_MARK;
            state_in    = S_RESP;
         end

         S_RESP: begin
            // Hold here until the output register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_cell_in   = res_cell_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         issue_done_ff <= 1'b0;
         proc_vld_ff   <= 1'b0;
         dst_ff        <= '0;
         rem_ff        <= '0;
         op_ff         <= cfa_pkg::OP_FIRST_FIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         issue_done_ff <= issue_done_in;
         proc_vld_ff   <= proc_vld_in;
         dst_ff        <= dst_in;
         rem_ff        <= rem_in;
         op_ff         <= op_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_addr_ff  <= proc_addr_in;
      owner_ff      <= owner_in;
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_cell_ff   <= res_cell_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_cell_ff   <= rsp_cell_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.alloc_start = rsp_start_ff;
   assign rsp_chan.cell_owner  = rsp_cell_ff;
endmodule

/* design/cfa_checker.sv */
`include "contiguous_fit_allocator_unit_assert.svh"

module cfa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cfa_pkg::status_type  rsp_status,
   input cfa_pkg::start_type   rsp_start,
   input cfa_pkg::owner_type   rsp_cell
);
   // Hold a stalled response.
   `CFA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "stalled response dropped")
   `CFA_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_start) && $stable(rsp_cell), "stalled response changed")
   // Ready is low when reset falls, as the clearing sweep of the pool begins.
   `CFA_ASSERT_IMP(a_clear_sweep, clock, reset, $fell(reset), !req_ready, "request taken during clearing sweep")
   // An invalid opcode carries zero fields.
   `CFA_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && (rsp_status == cfa_pkg::STATUS_INVALID), (rsp_start == '0) && (rsp_cell == '0), "invalid response carries data")
endmodule

bind contiguous_fit_allocator_unit cfa_checker u_cfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_start  (rsp_chan.alloc_start),
   .rsp_cell   (rsp_chan.cell_owner)
);
